// File: hw/rtl/lrufr_pkg.sv
// Shared types, constants and widths for the LRU frame replacer.
package lrufr_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int IDX_W      = $clog2(NUM_FRAMES);
  localparam int FRAME_W    = 6;
  localparam int CNT_W      = 7;
  localparam int PIN_W      = 8;
  localparam int OP_W       = 2;

  localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_VICTIM = 2'd0,
    OP_PIN    = 2'd1,
    OP_UNPIN  = 2'd2
  } op_t;

  // State seen by the update logic for the beat in the work stage
  typedef struct packed {
    logic             tracked;
    logic             evictable;
    logic [PIN_W-1:0] pin;
    logic [IDX_W-1:0] older;
    logic [IDX_W-1:0] newer;
    logic [IDX_W-1:0] oldest;
    logic [IDX_W-1:0] newest;
    logic [CNT_W-1:0] total;
  } view_t;

  // Writes and next values produced for one beat
  typedef struct packed {
    logic             flag_we;
    logic [IDX_W-1:0] flag_idx;
    logic             tracked_val;
    logic             evict_val;
    logic             pin_we;
    logic [PIN_W-1:0] pin_val;
    logic             newer_we;
    logic [IDX_W-1:0] newer_addr;
    logic [IDX_W-1:0] newer_val;
    logic             older_we;
    logic [IDX_W-1:0] older_addr;
    logic [IDX_W-1:0] older_val;
    logic [IDX_W-1:0] oldest_nxt;
    logic [IDX_W-1:0] newest_nxt;
    logic [CNT_W-1:0] total_nxt;
    logic             victim_valid;
    logic [IDX_W-1:0] victim_idx;
  } upd_t;

endpackage

// File: hw/rtl/lrufr_chan_if.sv
// Valid/ready channel interfaces for request and result beats.
interface lrufr_in_if;
  logic                             valid;
  logic                             ready;
  logic [lrufr_pkg::OP_W-1:0]       opcode;
  logic [lrufr_pkg::FRAME_W-1:0]    frame_number;

  modport source (output valid, output opcode, output frame_number, input ready);
  modport sink   (input valid, input opcode, input frame_number, output ready);
endinterface

interface lrufr_out_if;
  logic                             valid;
  logic                             ready;
  logic                             victim_valid;
  logic [lrufr_pkg::FRAME_W-1:0]    victim_frame;
  logic [lrufr_pkg::CNT_W-1:0]      evictable_count;

  modport source (output valid, output victim_valid, output victim_frame,
                  output evictable_count, input ready);
  modport sink   (input valid, input victim_valid, input victim_frame,
                  input evictable_count, output ready);
endinterface

// File: hw/rtl/lrufr_ram.sv
// Generic one-write one-read RAM, registered read, write-first on collision.
module lrufr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

// File: hw/rtl/lrufr_update.sv
// Next-state logic for one beat: list unlink/append, pin count, flag writes.
module lrufr_update (
  input  lrufr_pkg::op_t                 op,
  input  logic [lrufr_pkg::FRAME_W-1:0]  frame,
  input  lrufr_pkg::view_t               view,
  output lrufr_pkg::upd_t                upd
);

  logic                            in_range;
  logic [lrufr_pkg::IDX_W-1:0]     f;
  logic                            do_remove;
  logic                            do_append;
  logic [lrufr_pkg::PIN_W-1:0]     pin_dec;

  assign in_range = {1'b0, frame} < (lrufr_pkg::FRAME_W+1)'(lrufr_pkg::NUM_FRAMES);
  assign f        = (op == lrufr_pkg::OP_VICTIM) ? view.oldest
                                                 : frame[lrufr_pkg::IDX_W-1:0];
  assign pin_dec  = (view.pin != '0) ? view.pin - 1'b1 : '0;

  always_comb begin
    upd              = '0;
    upd.flag_idx     = f;
    upd.oldest_nxt   = view.oldest;
    upd.newest_nxt   = view.newest;
    upd.total_nxt    = view.total;
    do_remove        = 1'b0;
    do_append        = 1'b0;

    case (op)
      lrufr_pkg::OP_VICTIM: begin
        if (view.total != '0) begin
          do_remove        = 1'b1;
          upd.victim_valid = 1'b1;
          upd.victim_idx   = f;
          upd.flag_we      = 1'b1;
          upd.tracked_val  = 1'b0;
          upd.evict_val    = 1'b0;
        end
      end
      lrufr_pkg::OP_PIN: begin
        if (in_range && view.tracked) begin
          upd.pin_we = 1'b1;
          if (view.evictable) begin
            do_remove       = 1'b1;
            upd.flag_we     = 1'b1;
            upd.tracked_val = 1'b1;
            upd.evict_val   = 1'b0;
            upd.pin_val     = lrufr_pkg::PIN_W'(1);
          end else begin
            // saturate at the top count
            upd.pin_val = (view.pin != lrufr_pkg::PIN_MAX) ? view.pin + 1'b1 : view.pin;
          end
        end
      end
      lrufr_pkg::OP_UNPIN: begin
        if (in_range) begin
          if (!view.tracked) begin
            do_append       = 1'b1;
            upd.pin_we      = 1'b1;
            upd.pin_val     = '0;
            upd.flag_we     = 1'b1;
            upd.tracked_val = 1'b1;
            upd.evict_val   = 1'b1;
          end else if (!view.evictable) begin
            upd.pin_we  = 1'b1;
            upd.pin_val = pin_dec;
            if (pin_dec == '0) begin
              do_append       = 1'b1;
              upd.flag_we     = 1'b1;
              upd.tracked_val = 1'b1;
              upd.evict_val   = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // unlink: patch neighbors, or move an end pointer when f sits at that end
    if (do_remove) begin
      if (f == view.oldest) begin
        upd.oldest_nxt = view.newer;
      end else begin
        upd.newer_we   = 1'b1;
        upd.newer_addr = view.older;
        upd.newer_val  = view.newer;
      end
      if (f == view.newest) begin
        upd.newest_nxt = view.older;
      end else begin
        upd.older_we   = 1'b1;
        upd.older_addr = view.newer;
        upd.older_val  = view.older;
      end
      upd.total_nxt = (view.total != '0) ? view.total - 1'b1 : '0;
    end

    if (do_append) begin
      if (view.total == '0) begin
        upd.oldest_nxt = f;
      end else begin
        upd.newer_we   = 1'b1;
        upd.newer_addr = view.newest;
        upd.newer_val  = f;
        upd.older_we   = 1'b1;
        upd.older_addr = f;
        upd.older_val  = view.newest;
      end
      upd.newest_nxt = f;
      upd.total_nxt  = view.total + 1'b1;
    end
  end

endmodule

// File: hw/rtl/lru_frame_replacer.sv
// Top level of the LRU frame replacer: work stage, list state, result register.
// Accepts one victim/pin/unpin beat per cycle unless the work stage is stalled
// by the result side, and returns exactly one result beat for each through the work stage and result register.
// The neighbor links and pin counts live in three small RAMs that are read
// in the cycle a beat is accepted (address from the beat's frame, or from the
// oldest list end for a victim request) and written when the beat completes;
// a write-first bypass covers back-to-back beats on the same frame. Tracked
// and evictable flags are flip-flops cleared by reset, so no clearing pass is
// needed after reset. The result register lets a new beat enter while a
// finished result still waits to be taken.
module lru_frame_replacer (
  input  logic         clk,
  input  logic         rst_n,
  lrufr_in_if.sink     in_ch,
  lrufr_out_if.source  out_ch
);

  localparam int IDX_W = lrufr_pkg::IDX_W;
  localparam int NF    = lrufr_pkg::NUM_FRAMES;

  // work stage
  logic                          b_valid_r;
  lrufr_pkg::op_t                b_op_r;
  logic [lrufr_pkg::FRAME_W-1:0] b_frame_r;

  // list state
  logic [NF-1:0]                 tracked_r;
  logic [NF-1:0]                 evictable_r;
  logic [IDX_W-1:0]              oldest_r;
  logic [IDX_W-1:0]              newest_r;
  logic [lrufr_pkg::CNT_W-1:0]   total_r;

  // result register
  logic                          out_valid_r;
  logic                          victim_valid_r;
  logic [lrufr_pkg::FRAME_W-1:0] victim_frame_r;
  logic [lrufr_pkg::CNT_W-1:0]   count_r;

  logic                          adv;
  logic                          in_acc;
  lrufr_pkg::op_t                in_op;
  logic [IDX_W-1:0]              rd_addr;
  logic [IDX_W-1:0]              oldest_next;
  logic [IDX_W-1:0]              b_idx;
  logic [IDX_W-1:0]              older_rd;
  logic [IDX_W-1:0]              newer_rd;
  logic [lrufr_pkg::PIN_W-1:0]   pin_rd;
  lrufr_pkg::view_t              view;
  lrufr_pkg::upd_t               upd;

  assign adv          = b_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !b_valid_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_op        = lrufr_pkg::op_t'(in_ch.opcode);
  assign b_idx        = b_frame_r[IDX_W-1:0];

  // read address uses the list ends as they stand after the completing beat
  assign oldest_next  = adv ? upd.oldest_nxt : oldest_r;
  assign rd_addr      = (in_op == lrufr_pkg::OP_VICTIM) ? oldest_next
                                                        : in_ch.frame_number[IDX_W-1:0];

  lrufr_ram #(.WIDTH(IDX_W), .DEPTH(NF)) u_older (
    .clk   (clk),
    .we    (adv && upd.older_we),
    .waddr (upd.older_addr),
    .wdata (upd.older_val),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (older_rd)
  );

  lrufr_ram #(.WIDTH(IDX_W), .DEPTH(NF)) u_newer (
    .clk   (clk),
    .we    (adv && upd.newer_we),
    .waddr (upd.newer_addr),
    .wdata (upd.newer_val),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (newer_rd)
  );

  lrufr_ram #(.WIDTH(lrufr_pkg::PIN_W), .DEPTH(NF)) u_pin (
    .clk   (clk),
    .we    (adv && upd.pin_we),
    .waddr (upd.flag_idx),
    .wdata (upd.pin_val),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (pin_rd)
  );

  always_comb begin
    view.tracked   = tracked_r[b_idx];
    view.evictable = evictable_r[b_idx];
    view.pin       = pin_rd;
    view.older     = older_rd;
    view.newer     = newer_rd;
    view.oldest    = oldest_r;
    view.newest    = newest_r;
    view.total     = total_r;
  end

  lrufr_update u_update (
    .op    (b_op_r),
    .frame (b_frame_r),
    .view  (view),
    .upd   (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_acc) begin
      b_valid_r <= 1'b1;
    end else if (adv) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_op_r    <= in_op;
      b_frame_r <= in_ch.frame_number;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracked_r   <= '0;
      evictable_r <= '0;
      oldest_r    <= '0;
      newest_r    <= '0;
      total_r     <= '0;
    end else if (adv) begin
      if (upd.flag_we) begin
        tracked_r[upd.flag_idx]   <= upd.tracked_val;
        evictable_r[upd.flag_idx] <= upd.evict_val;
      end
      oldest_r <= upd.oldest_nxt;
      newest_r <= upd.newest_nxt;
      total_r  <= upd.total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      victim_valid_r <= upd.victim_valid;
      victim_frame_r <= upd.victim_valid ? lrufr_pkg::FRAME_W'(upd.victim_idx) : '0;
      count_r        <= upd.total_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.victim_valid    = victim_valid_r;
  assign out_ch.victim_frame    = victim_frame_r;
  assign out_ch.evictable_count = count_r;

  // list length always matches the evictable flags
  a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(evictable_r) == int'(total_r))
    else $error("evictable total out of step with flags");

  // an evictable frame is always a tracked frame
  a_evict_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (evictable_r & ~tracked_r) == '0)
    else $error("evictable frame not tracked");

  // a granted victim leaves at least one slot free in the list
  a_victim_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.victim_valid) |->
      (out_ch.evictable_count < lrufr_pkg::CNT_W'(NF)))
    else $error("victim reported with full list");

  // a stalled work-stage beat stays put
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !adv) |=> (b_valid_r && $stable(b_op_r) && $stable(b_frame_r)))
    else $error("work stage lost a stalled beat");

endmodule
